// ===== sv/tbsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-button stopwatch / countdown: shared package
// Types, register indexes, mode codes and the saturating timer helpers used
// by the debouncers, the timing core and the top level.
// ----------------------------------------------------------------------------
package tbsc_pkg;

    // Width of every elapsed-time counter.
    localparam int TIMER_BITS = 16;
    // Width used when a timer is compared against a register value.
    localparam int CMP_BITS   = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    typedef logic [TIMER_BITS-1:0] timer_t;
    localparam timer_t TIMER_MAX = '1;

    // LED toggle interval once the countdown has expired.
    localparam logic [15:0] TIMEUP_BLINK_MS = 16'd700;
    localparam logic [9:0]  PRESET_RESET    = 10'd10;
    localparam logic [15:0] SW_MAX          = 16'hFFFF;

    // Mode codes as seen on the result channel.
    typedef logic [1:0] mode_t;
    localparam mode_t MODE_IDLE = 2'd0;
    localparam mode_t MODE_SW   = 2'd1;
    localparam mode_t MODE_CD   = 2'd2;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_SETTLE_MS      = 3'd0,
        REG_LONG_PRESS_MS  = 3'd1,
        REG_STEP_GAP_MS    = 3'd2,
        REG_SECOND_MS      = 3'd3,
        REG_RUN_BLINK_MS   = 3'd4,
        REG_PRESET_STEP    = 3'd5,
        REG_PRESET_MIN     = 3'd6,
        REG_PRESET_MAX     = 3'd7
    } reg_index_t;

    // Configuration register file contents.
    typedef struct packed {
        logic [9:0]  settle_ms;
        logic [11:0] long_press_ms;
        logic [11:0] step_gap_ms;
        logic [15:0] second_ms;
        logic [11:0] run_blink_ms;
        logic [7:0]  preset_step;
        logic [9:0]  preset_min;
        logic [9:0]  preset_max;
    } cfg_t;

    // Per-tick events reported by one button debouncer.
    typedef struct packed {
        logic click;        // short press released
        logic press_start;  // stable level has just gone low
        logic long_active;  // held low at least the long-press time
        logic long_new;     // long hold seen for the first time in this press
    } btn_event_t;

    // One result transaction.
    typedef struct packed {
        mode_t       mode;
        logic [15:0] stopwatch_seconds;
        logic [9:0]  countdown_seconds;
        logic [9:0]  countdown_preset;
        logic        stopwatch_running;
        logic        countdown_running;
        logic        time_up;
        logic        led;
    } result_t;

    // Saturating increment of an elapsed-time counter.
    function automatic timer_t tick_up(input timer_t t);
        return (t != TIMER_MAX) ? t + timer_t'(1) : TIMER_MAX;
    endfunction

    // Widen a timer for comparison.
    function automatic logic [CMP_BITS-1:0] tcmp(input timer_t t);
        return CMP_BITS'(t);
    endfunction

    // Widen a register value for comparison.
    function automatic logic [CMP_BITS-1:0] vcmp(input logic [15:0] v);
        return CMP_BITS'(v);
    endfunction

endpackage

// ===== sv/two_button_stopwatch_countdown.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-button stopwatch / countdown controller
// Takes one millisecond tick per transaction carrying two raw button levels
// and returns one result transaction with mode, timer values and LED drive.
// ----------------------------------------------------------------------------
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+-----------------------------------
//  item     | item_valid, item_stall     | button_a_raw, button_b_raw
//  result   | result_valid, result_stall | mode, seconds, preset, flags, led
//  cfg      | cfg_valid, cfg_ready       | cfg_index, cfg_data
//
// A tick is captured in the input register, processed combinationally by the
// debouncers and the timing core, and lands in the result register; one
// transaction per cycle is sustained while the result channel is not stalled.
// A stalled, full result register holds its contents and a full input register;
// item_stall rises only when the input register is full and cannot move on.
// Reset clears the handshake and all timing state and loads register defaults.
// Configuration writes are accepted in every cycle.
// ----------------------------------------------------------------------------
module two_button_stopwatch_countdown
    import tbsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        item_valid,
    output logic        item_stall,
    input  logic        button_a_raw,
    input  logic        button_b_raw,

    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  mode,
    output logic [15:0] stopwatch_seconds,
    output logic [9:0]  countdown_seconds,
    output logic [9:0]  countdown_preset,
    output logic        stopwatch_running,
    output logic        countdown_running,
    output logic        time_up,
    output logic        led,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic       in_valid_reg;
    logic       raw_a_reg;
    logic       raw_b_reg;
    logic       out_valid_reg;
    result_t    result_reg;
    result_t    result_next;
    cfg_t       cfg_reg;
    logic       advance;
    btn_event_t a_evt;
    btn_event_t b_evt;

    // Handshake: a tick moves on when the result register is free or draining.
    assign advance    = in_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = in_valid_reg && !advance;
    assign cfg_ready  = 1'b1;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            raw_a_reg <= button_a_raw;
            raw_b_reg <= button_b_raw;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_ms      <= 10'd50;
            cfg_reg.long_press_ms  <= 12'd800;
            cfg_reg.step_gap_ms    <= 12'd350;
            cfg_reg.second_ms      <= 16'd1000;
            cfg_reg.run_blink_ms   <= 12'd500;
            cfg_reg.preset_step    <= 8'd10;
            cfg_reg.preset_min     <= 10'd10;
            cfg_reg.preset_max     <= 10'd300;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_SETTLE_MS:      cfg_reg.settle_ms      <= cfg_data[9:0];
                REG_LONG_PRESS_MS:  cfg_reg.long_press_ms  <= cfg_data[11:0];
                REG_STEP_GAP_MS:    cfg_reg.step_gap_ms    <= cfg_data[11:0];
                REG_SECOND_MS:      cfg_reg.second_ms      <= cfg_data;
                REG_RUN_BLINK_MS:   cfg_reg.run_blink_ms   <= cfg_data[11:0];
                REG_PRESET_STEP:    cfg_reg.preset_step    <= cfg_data[7:0];
                REG_PRESET_MIN:     cfg_reg.preset_min     <= cfg_data[9:0];
                REG_PRESET_MAX:     cfg_reg.preset_max     <= cfg_data[9:0];
                default:            cfg_reg.preset_max     <= cfg_reg.preset_max;
            endcase
        end
    end

    // Button front ends.
    tbsc_debounce u_deb_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .raw     (raw_a_reg),
        .cfg     (cfg_reg),
        .evt     (a_evt)
    );

    tbsc_debounce u_deb_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .raw     (raw_b_reg),
        .cfg     (cfg_reg),
        .evt     (b_evt)
    );

    // Mode, timers and LED.
    tbsc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .cfg         (cfg_reg),
        .a_evt       (a_evt),
        .b_evt       (b_evt),
        .result_next (result_next)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !result_stall)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid      = out_valid_reg;
    assign mode              = result_reg.mode;
    assign stopwatch_seconds = result_reg.stopwatch_seconds;
    assign countdown_seconds = result_reg.countdown_seconds;
    assign countdown_preset  = result_reg.countdown_preset;
    assign stopwatch_running = result_reg.stopwatch_running;
    assign countdown_running = result_reg.countdown_running;
    assign time_up           = result_reg.time_up;
    assign led               = result_reg.led;

    // The input register backs up only behind a full, stalled result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (in_valid_reg && out_valid_reg && result_stall))
    else $error("input stalled without a blocked result");

    // The two timers never run at the same time.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(stopwatch_running && countdown_running))
    else $error("stopwatch and countdown both running");

    // An expired countdown is never still running.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && time_up) |-> !countdown_running)
    else $error("time-up raised while countdown running");

    // A processed tick always appears on the result channel next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid)
    else $error("processed tick did not reach the result register");

endmodule

// ===== sv/tbsc_debounce.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button debouncer and press timer
// Filters one active-low raw button level, times the press and reports
// clicks, press starts and long holds for the tick being processed.
// ----------------------------------------------------------------------------
module tbsc_debounce
    import tbsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic       raw,
    input  cfg_t       cfg,
    output btn_event_t evt
);

    logic   last_raw_reg, last_raw_next;
    logic   stable_reg, stable_next;
    timer_t quiet_reg, quiet_next;
    timer_t press_reg, press_next;
    logic   engaged_reg, engaged_next;

    // Debounce, press timing and long-hold detection for one tick.
    always_comb
    begin
        evt          = '0;
        stable_next  = stable_reg;
        engaged_next = engaged_reg;
        press_next   = tick_up(press_reg);
        quiet_next   = tick_up(quiet_reg);
        if (raw != last_raw_reg)
        begin
            quiet_next = '0;
        end
        if ((tcmp(quiet_next) > vcmp(16'(cfg.settle_ms))) && (stable_reg != raw))
        begin
            stable_next = raw;
            if (!raw)
            begin
                press_next      = '0;
                engaged_next    = 1'b0;
                evt.press_start = 1'b1;
            end
            else if (!engaged_reg
                     && (tcmp(press_next) < vcmp(16'(cfg.long_press_ms))))
            begin
                evt.click = 1'b1;
            end
        end
        evt.long_active = !stable_next
                          && (tcmp(press_next) >= vcmp(16'(cfg.long_press_ms)));
        evt.long_new    = evt.long_active && !engaged_next;
        if (evt.long_active)
        begin
            engaged_next = 1'b1;
        end
        last_raw_next = raw;
    end

    // State registers, updated once per processed tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg <= 1'b1;
            stable_reg   <= 1'b1;
            quiet_reg    <= '0;
            press_reg    <= '0;
            engaged_reg  <= 1'b0;
        end
        else if (advance)
        begin
            last_raw_reg <= last_raw_next;
            stable_reg   <= stable_next;
            quiet_reg    <= quiet_next;
            press_reg    <= press_next;
            engaged_reg  <= engaged_next;
        end
    end

endmodule

// ===== sv/tbsc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stopwatch / countdown timing core
// Holds the mode, both timers, the preset, the seconds divider and the LED
// blinker, and computes the next result from the two button event sets.
// ----------------------------------------------------------------------------
module tbsc_core
    import tbsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  cfg_t       cfg,
    input  btn_event_t a_evt,
    input  btn_event_t b_evt,
    output result_t    result_next
);

    mode_t       mode_reg, mode_next;
    logic [15:0] sw_count_reg, sw_count_next;
    logic        sw_run_reg, sw_run_next;
    logic [9:0]  cd_count_reg, cd_count_next;
    logic        cd_run_reg, cd_run_next;
    logic        cd_done_reg, cd_done_next;
    logic [9:0]  preset_reg, preset_next;
    timer_t      repeat_reg, repeat_next;
    timer_t      second_reg, second_next;
    timer_t      blink_reg, blink_next;
    logic        led_level_reg, led_level_next;
    logic [10:0] preset_sum;

    // Button actions, seconds divider and LED for one tick, in that order.
    always_comb
    begin
        mode_next      = mode_reg;
        sw_count_next  = sw_count_reg;
        sw_run_next    = sw_run_reg;
        cd_count_next  = cd_count_reg;
        cd_run_next    = cd_run_reg;
        cd_done_next   = cd_done_reg;
        preset_next    = preset_reg;
        led_level_next = led_level_reg;
        repeat_next    = tick_up(repeat_reg);
        second_next    = tick_up(second_reg);
        blink_next     = tick_up(blink_reg);
        preset_sum     = 11'(preset_reg) + 11'(cfg.preset_step);

        // Short click of A: enter the stopwatch or toggle run and pause.
        if (a_evt.click)
        begin
            if (mode_reg != MODE_SW)
            begin
                mode_next    = MODE_SW;
                sw_run_next  = 1'b1;
                cd_run_next  = 1'b0;
                cd_done_next = 1'b0;
            end
            else
            begin
                sw_run_next = !sw_run_reg;
            end
        end

        // A fresh press of B restarts the hold repeat interval.
        if (b_evt.press_start)
        begin
            repeat_next = '0;
        end

        // Short click of B: start, pause or reload the countdown.
        if (b_evt.click)
        begin
            mode_next    = MODE_CD;
            sw_run_next  = 1'b0;
            cd_done_next = 1'b0;
            if (cd_run_next)
            begin
                cd_run_next = 1'b0;
            end
            else
            begin
                if (cd_count_next == 10'd0)
                begin
                    cd_count_next = preset_reg;
                end
                cd_run_next = 1'b1;
            end
        end

        // Long hold of A clears both timers and all run and time-up flags back to idle.
        if (a_evt.long_new)
        begin
            sw_count_next = '0;
            cd_count_next = '0;
            sw_run_next   = 1'b0;
            cd_run_next   = 1'b0;
            cd_done_next  = 1'b0;
            mode_next     = MODE_IDLE;
        end

        // Long hold of B steps the preset, wrapping past the maximum.
        if (b_evt.long_active
            && (tcmp(repeat_next) >= vcmp(16'(cfg.step_gap_ms))))
        begin
            if (preset_sum > 11'(cfg.preset_max))
            begin
                preset_next = cfg.preset_min;
            end
            else
            begin
                preset_next = preset_sum[9:0];
            end
            mode_next   = MODE_IDLE;
            repeat_next = '0;
        end

        // Seconds divider.
        if (tcmp(second_next) >= vcmp(cfg.second_ms))
        begin
            second_next = '0;
            if (sw_run_next && (sw_count_next != SW_MAX))
            begin
                sw_count_next = sw_count_next + 16'd1;
            end
            if (cd_run_next && (cd_count_next != 10'd0))
            begin
                if (cd_count_next == 10'd1)
                begin
                    cd_run_next  = 1'b0;
                    cd_done_next = 1'b1;
                end
                cd_count_next = cd_count_next - 10'd1;
            end
        end

        // LED blinker.
        if (sw_run_next || cd_run_next)
        begin
            if (tcmp(blink_next) >= vcmp(16'(cfg.run_blink_ms)))
            begin
                blink_next     = '0;
                led_level_next = !led_level_reg;
            end
        end
        else if (cd_done_next)
        begin
            if (tcmp(blink_next) >= vcmp(TIMEUP_BLINK_MS))
            begin
                blink_next     = '0;
                led_level_next = !led_level_reg;
            end
        end
        else
        begin
            led_level_next = 1'b0;
        end

        result_next.mode              = mode_next;
        result_next.stopwatch_seconds = sw_count_next;
        result_next.countdown_seconds = cd_count_next;
        result_next.countdown_preset  = preset_next;
        result_next.stopwatch_running = sw_run_next;
        result_next.countdown_running = cd_run_next;
        result_next.time_up           = cd_done_next;
        result_next.led               = led_level_next
                                        || ((mode_next == MODE_CD) && (cd_count_next == 10'd0));
    end

    // State registers, updated once per processed tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            sw_count_reg  <= '0;
            sw_run_reg    <= 1'b0;
            cd_count_reg  <= '0;
            cd_run_reg    <= 1'b0;
            cd_done_reg   <= 1'b0;
            preset_reg    <= PRESET_RESET;
            repeat_reg    <= '0;
            second_reg    <= '0;
            blink_reg     <= '0;
            led_level_reg <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg      <= mode_next;
            sw_count_reg  <= sw_count_next;
            sw_run_reg    <= sw_run_next;
            cd_count_reg  <= cd_count_next;
            cd_run_reg    <= cd_run_next;
            cd_done_reg   <= cd_done_next;
            preset_reg    <= preset_next;
            repeat_reg    <= repeat_next;
            second_reg    <= second_next;
            blink_reg     <= blink_next;
            led_level_reg <= led_level_next;
        end
    end

endmodule
